[sv/saclf_pkg.sv]
`default_nettype none
package saclf_pkg;

	localparam int WAYS_DEF      = 4;
	localparam int SETS_DEF      = 256;
	localparam int ADDR_W        = 32;
	localparam int TAG_W         = 32;
	localparam int STAMP_W       = 32;
	localparam int CNT_W         = 32;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 32;
	localparam int SET_RAW_W     = 15;
	// reciprocal shift: exact quotient for 15-bit dividends and divisors up to 4096
	localparam int SET_DIV_SHIFT = 27;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WAYS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 3'd3;

	localparam logic POLICY_LRU  = 1'b0;
	localparam logic POLICY_FIFO = 1'b1;

	localparam logic [4:0] OFFSET_BITS_RST = 5'd6;
	localparam logic [3:0] SET_BITS_RST    = 4'd0;
	localparam logic [2:0] ACTIVE_WAYS_RST = 3'd4;

	typedef struct packed {
		logic [4:0] offset_bits;
		logic [3:0] set_bits;
		logic [2:0] active_ways;
		logic       policy;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK
	} back_state_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
	endfunction

endpackage
`default_nettype wire

[sv/saclf_if.sv]
`default_nettype none
interface saclf_addr_if;
	logic                          valid;
	logic                          ready;
	logic [saclf_pkg::ADDR_W-1:0]  address;
	modport source (output valid, output address, input ready);
	modport sink (input valid, input address, output ready);
endinterface

interface saclf_res_if;
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic [saclf_pkg::CNT_W-1:0]   hit_total;
	logic [saclf_pkg::CNT_W-1:0]   miss_total;
	modport source (output valid, output hit, output hit_total, output miss_total,
		input ready);
	modport sink (input valid, input hit, input hit_total, input miss_total,
		output ready);
endinterface

interface saclf_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [saclf_pkg::CFG_IDX_W-1:0]   index;
	logic [saclf_pkg::CFG_DATA_W-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[sv/saclf_front.sv]
`default_nettype none
module saclf_front #(
	parameter int SETS = saclf_pkg::SETS_DEF,
	localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire saclf_pkg::cfg_t                 cfg,
	input  wire logic                            clearing,
	saclf_addr_if.sink                           access,
	output logic                                 push_valid,
	input  wire logic                            push_ready,
	output logic [saclf_pkg::TAG_W+SET_W-1:0]    push_data
);
	import saclf_pkg::*;

	localparam int RECIP_W = SET_DIV_SHIFT + 1;
	localparam int PROD_W  = SET_RAW_W + RECIP_W;
	localparam int QUOT_W  = PROD_W - SET_DIV_SHIFT;
	localparam logic [RECIP_W-1:0] SET_RECIP =
		RECIP_W'((2**SET_DIV_SHIFT + SETS - 1) / SETS);

	logic                  v_s1, v_s2;
	logic [TAG_W-1:0]      tag_s1, tag_s2;
	logic [SET_RAW_W-1:0]  raw_s1, raw_s2;
	logic [PROD_W-1:0]     prod_s2;
	logic                  en_s1, en_s2;
	logic [ADDR_W-1:0]     line;
	logic [SET_RAW_W-1:0]  set_mask;
	logic [QUOT_W-1:0]     quot;
	logic [31:0]           rem;

	assign en_s2 = !v_s2 || push_ready;
	assign en_s1 = !v_s1 || en_s2;
	assign access.ready = en_s1 && !clearing;

	always_comb begin
		line     = access.address >> cfg.offset_bits;
		set_mask = SET_RAW_W'((16'd1 << cfg.set_bits) - 16'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= access.valid && !clearing;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			tag_s1 <= line >> cfg.set_bits;
			raw_s1 <= line[SET_RAW_W-1:0] & set_mask;
		end
		if (en_s2) begin
			tag_s2  <= tag_s1;
			raw_s2  <= raw_s1;
			prod_s2 <= PROD_W'(raw_s1) * PROD_W'(SET_RECIP);
		end
	end

	// set index modulo SETS: quotient from the reciprocal product, then one subtract
	always_comb begin
		quot = prod_s2[PROD_W-1:SET_DIV_SHIFT];
		rem  = 32'(raw_s2) - 32'(quot) * 32'(SETS);
	end

	assign push_valid = v_s2;
	assign push_data  = {tag_s2, rem[SET_W-1:0]};

endmodule
`default_nettype wire

[sv/saclf_queue.sv]
`default_nettype none
module saclf_queue #(
	parameter int W = 40
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [W-1:0]  in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [W-1:0]       out_data
);
	import saclf_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]       entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_QW-1:0]  count_q;
	logic               push, pop;

	assign in_ready  = count_q != CNT_QW'(QUEUE_DEPTH);
	assign out_valid = count_q != '0;
	assign out_data  = entry_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop) count_q <= count_q + CNT_QW'(1);
			else if (pop && !push) count_q <= count_q - CNT_QW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= in_data;
	end

endmodule
`default_nettype wire

[sv/saclf_back.sv]
`default_nettype none
module saclf_back #(
	parameter int WAYS = saclf_pkg::WAYS_DEF,
	parameter int SETS = saclf_pkg::SETS_DEF,
	localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire saclf_pkg::cfg_t                 cfg,
	input  wire logic                            q_valid,
	output logic                                 q_ready,
	input  wire logic [saclf_pkg::TAG_W+SET_W-1:0] q_data,
	output logic                                 clearing,
	saclf_res_if.source                          result
);
	import saclf_pkg::*;

	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int P2    = 1 << $clog2(WAYS);

	logic [WAYS-1:0]                valid_mem [SETS];
	logic [WAYS-1:0][TAG_W-1:0]     tag_mem   [SETS];
	logic [WAYS-1:0][STAMP_W-1:0]   stamp_mem [SETS];

	logic [WAYS-1:0]                rd_valid_q;
	logic [WAYS-1:0][TAG_W-1:0]     rd_tag_q;
	logic [WAYS-1:0][STAMP_W-1:0]   rd_stamp_q;
	logic [TAG_W-1:0]               tag_q;
	logic [SET_W-1:0]               set_q;

	back_state_t                    state_q, state_d;
	logic [SET_W-1:0]               clr_cnt_q;
	logic [STAMP_W-1:0]             gstamp_q;
	logic [CNT_W-1:0]               hits_q, misses_q;
	logic                           res_valid_q, res_hit_q;
	logic [CNT_W-1:0]               res_hits_q, res_misses_q;

	logic                           out_free, rd_en, commit, clr_we;
	logic [WAY_W:0]                 nways;
	logic [WAYS-1:0]                act;
	logic                           hit, empty_found, upd_stamp;
	logic [WAY_W-1:0]               hit_way, empty_way, victim;
	logic [STAMP_W-1:0]             gs_next;
	logic                           node_act   [2*P2];
	logic [STAMP_W-1:0]             node_stamp [2*P2];
	logic [WAY_W-1:0]               node_way   [2*P2];
	logic [WAYS-1:0]                new_valid;
	logic [WAYS-1:0][TAG_W-1:0]     new_tag;
	logic [WAYS-1:0][STAMP_W-1:0]   new_stamp;

	assign out_free = !res_valid_q || result.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_cnt_q == SET_W'(SETS - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (q_valid) state_d = ST_LOOK;
			ST_LOOK:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		q_ready  = 1'b0;
		rd_en    = 1'b0;
		commit   = 1'b0;
		clr_we   = 1'b0;
		unique case (state_q)
			ST_CLEAR: clr_we = 1'b1;
			ST_IDLE: begin
				q_ready = 1'b1;
				rd_en   = q_valid;
			end
			ST_LOOK:  commit = out_free;
			default: ;
		endcase
	end

	assign clearing = (state_q == ST_CLEAR);

	// way search, first empty way, a compare tree for the oldest stamp, and the new set row
	always_comb begin
		if (cfg.active_ways == 3'd0) nways = (WAY_W+1)'(1);
		else if (int'(cfg.active_ways) > WAYS) nways = (WAY_W+1)'(WAYS);
		else nways = (WAY_W+1)'(cfg.active_ways);

		for (int w = 0; w < WAYS; w++) act[w] = (WAY_W+1)'(w) < nways;

		hit         = 1'b0;
		hit_way     = '0;
		empty_found = 1'b0;
		empty_way   = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (!hit && act[w] && rd_valid_q[w] && rd_tag_q[w] == tag_q) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!empty_found && act[w] && !rd_valid_q[w]) begin
				empty_found = 1'b1;
				empty_way   = WAY_W'(w);
			end
		end

		for (int i = 0; i < 2*P2; i++) begin
			node_act[i]   = 1'b0;
			node_stamp[i] = '0;
			node_way[i]   = '0;
		end
		for (int i = 0; i < WAYS; i++) begin
			node_act[P2+i]   = act[i];
			node_stamp[P2+i] = rd_stamp_q[i];
			node_way[P2+i]   = WAY_W'(i);
		end
		// ties keep the left child, the lower way
		for (int n = P2 - 1; n >= 1; n--) begin
			if (node_act[2*n] && (!node_act[2*n+1] || node_stamp[2*n] <= node_stamp[2*n+1]))
			begin
				node_act[n]   = node_act[2*n];
				node_stamp[n] = node_stamp[2*n];
				node_way[n]   = node_way[2*n];
			end else begin
				node_act[n]   = node_act[2*n+1];
				node_stamp[n] = node_stamp[2*n+1];
				node_way[n]   = node_way[2*n+1];
			end
		end

		victim    = empty_found ? empty_way : node_way[1];
		gs_next   = sat_inc(gstamp_q);
		new_valid = rd_valid_q;
		new_tag   = rd_tag_q;
		new_stamp = rd_stamp_q;
		upd_stamp = 1'b0;
		if (hit) begin
			if (cfg.policy == POLICY_LRU) begin
				new_stamp[hit_way] = gs_next;
				upd_stamp          = 1'b1;
			end
		end else begin
			new_valid[victim] = 1'b1;
			new_tag[victim]   = tag_q;
			new_stamp[victim] = gs_next;
			upd_stamp         = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_we) valid_mem[clr_cnt_q] <= '0;
		else if (commit) valid_mem[set_q] <= new_valid;
		if (commit) begin
			tag_mem[set_q]   <= new_tag;
			stamp_mem[set_q] <= new_stamp;
		end
		if (rd_en) begin
			rd_valid_q <= valid_mem[q_data[SET_W-1:0]];
			rd_tag_q   <= tag_mem[q_data[SET_W-1:0]];
			rd_stamp_q <= stamp_mem[q_data[SET_W-1:0]];
			tag_q      <= q_data[TAG_W+SET_W-1:SET_W];
			set_q      <= q_data[SET_W-1:0];
		end
		if (commit) begin
			res_hit_q    <= hit;
			res_hits_q   <= hit ? sat_inc(hits_q) : hits_q;
			res_misses_q <= hit ? misses_q : sat_inc(misses_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			gstamp_q    <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_we) clr_cnt_q <= clr_cnt_q + SET_W'(1);
			if (commit) begin
				if (upd_stamp) gstamp_q <= gs_next;
				if (hit) hits_q <= sat_inc(hits_q);
				else misses_q <= sat_inc(misses_q);
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid      = res_valid_q;
	assign result.hit        = res_hit_q;
	assign result.hit_total  = res_hits_q;
	assign result.miss_total = res_misses_q;

endmodule
`default_nettype wire

[sv/set_assoc_cache_lru_fifo_core.sv]
`default_nettype none
// An address item passes the front stages and the queue before its set row is read.
// The set memory is read-modify-write, so a new item is taken only after the last is
// written back: the row is read in ST_IDLE, then ways are compared and it is written
// back in ST_LOOK. Reset: a clearing pass empties every way; no address item is accepted
// during it, configuration writes are. Registers reset to their documented values.
module set_assoc_cache_lru_fifo_core #(
	parameter int WAYS = saclf_pkg::WAYS_DEF,
	parameter int SETS = saclf_pkg::SETS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	saclf_cfg_if.sink    cfg,
	saclf_addr_if.sink   access,
	saclf_res_if.source  result
);
	import saclf_pkg::*;

	localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;

	cfg_t                   cfg_q, cfg_d;
	logic                   clearing;
	logic                   push_valid, push_ready;
	logic [TAG_W+SET_W-1:0] push_data;
	logic                   pop_valid, pop_ready;
	logic [TAG_W+SET_W-1:0] pop_data;

	assign cfg.ready = 1'b1;

	always_comb begin
		cfg_d = cfg_q;
		if (cfg.valid) begin
			unique case (cfg.index)
				CFG_OFFSET_BITS: cfg_d.offset_bits = cfg.data[4:0];
				CFG_SET_BITS:    cfg_d.set_bits    = cfg.data[3:0];
				CFG_ACTIVE_WAYS: cfg_d.active_ways = cfg.data[2:0];
				CFG_POLICY:      cfg_d.policy      = cfg.data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_bits <= OFFSET_BITS_RST;
			cfg_q.set_bits    <= SET_BITS_RST;
			cfg_q.active_ways <= ACTIVE_WAYS_RST;
			cfg_q.policy      <= POLICY_LRU;
		end else begin
			cfg_q <= cfg_d;
		end
	end

	saclf_front #(.SETS(SETS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.clearing   (clearing),
		.access     (access),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	saclf_queue #(.W(TAG_W + SET_W)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_valid),
		.in_ready  (push_ready),
		.in_data   (push_data),
		.out_valid (pop_valid),
		.out_ready (pop_ready),
		.out_data  (pop_data)
	);

	saclf_back #(.WAYS(WAYS), .SETS(SETS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (pop_valid),
		.q_ready  (pop_ready),
		.q_data   (pop_data),
		.clearing (clearing),
		.result   (result)
	);

endmodule
`default_nettype wire

[tb/set_assoc_cache_lru_fifo_core_tb.sv]
`default_nettype none
module set_assoc_cache_lru_fifo_core_tb;
	import saclf_pkg::*;

	localparam int WAYS            = WAYS_DEF;
	localparam int SETS            = SETS_DEF;
	localparam int LATENCY         = 4;
	localparam int HOLD_CYCLES     = 300;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 50;
	// no register lives here, writes to it must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd5;

	typedef struct packed {
		logic             hit;
		logic [CNT_W-1:0] hit_total;
		logic [CNT_W-1:0] miss_total;
	} lookup_t;

	logic clk;
	logic arst_n;

	saclf_cfg_if  cfg_if ();
	saclf_addr_if acc_if ();
	saclf_res_if  res_if ();

	set_assoc_cache_lru_fifo_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.access (acc_if),
		.result (res_if)
	);

	// tag store as the block should hold it
	cfg_t               cfg_now;
	logic               line_valid [SETS][WAYS];
	logic [TAG_W-1:0]   line_tag   [SETS][WAYS];
	logic [STAMP_W-1:0] line_stamp [SETS][WAYS];
	logic [STAMP_W-1:0] stamp_now;
	logic [CNT_W-1:0]   hits_seen;
	logic [CNT_W-1:0]   misses_seen;

	lookup_t pending_results[$];
	int      mismatches   = 0;
	int      idle_cycles  = 0;
	bit      no_gaps      = 1'b0;
	bit      hold_request = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] sat_bump(input logic [31:0] v);
		return (&v) ? v : v + 32'd1;
	endfunction

	function automatic lookup_t predict_access(input logic [ADDR_W-1:0] addr);
		logic [63:0]      line_no;
		logic [TAG_W-1:0] tag;
		int               set_idx;
		int               nways;
		int               victim;
		int               hit_way;
		bit               hit;
		bit               found_empty;
		lookup_t          r;
		line_no = {32'd0, addr} >> cfg_now.offset_bits;
		set_idx = int'((line_no & ((64'd1 << cfg_now.set_bits) - 64'd1)) % 64'(SETS));
		tag     = TAG_W'(line_no >> cfg_now.set_bits);
		nways   = int'(cfg_now.active_ways);
		if (nways < 1)
			nways = 1;
		if (nways > WAYS)
			nways = WAYS;
		hit     = 1'b0;
		hit_way = 0;
		for (int w = 0; w < nways; w++) begin
			if (!hit && line_valid[set_idx][w] && line_tag[set_idx][w] == tag) begin
				hit     = 1'b1;
				hit_way = w;
			end
		end
		if (hit) begin
			hits_seen = sat_bump(hits_seen);
			if (cfg_now.policy == POLICY_LRU) begin
				stamp_now = sat_bump(stamp_now);
				line_stamp[set_idx][hit_way] = stamp_now;
			end
		end else begin
			victim      = 0;
			found_empty = 1'b0;
			for (int w = 0; w < nways; w++) begin
				if (!found_empty && !line_valid[set_idx][w]) begin
					victim      = w;
					found_empty = 1'b1;
				end
			end
			// strict compare keeps the lowest way on equal stamps
			if (!found_empty) begin
				for (int w = 1; w < nways; w++) begin
					if (line_stamp[set_idx][w] < line_stamp[set_idx][victim])
						victim = w;
				end
			end
			misses_seen = sat_bump(misses_seen);
			stamp_now   = sat_bump(stamp_now);
			line_valid[set_idx][victim] = 1'b1;
			line_tag[set_idx][victim]   = tag;
			line_stamp[set_idx][victim] = stamp_now;
		end
		r.hit        = hit;
		r.hit_total  = hits_seen;
		r.miss_total = misses_seen;
		return r;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// random bits above the field width, which the register must drop
	function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] v,
		input int w);
		return $urandom_range(0, 1) ? (v | ($urandom << w)) : v;
	endfunction

	task automatic send_access(input logic [ADDR_W-1:0] addr);
		int gap;
		gap = no_gaps ? 0 : idle_len();
		if (gap > 0) begin
			acc_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		acc_if.valid   <= 1'b1;
		acc_if.address <= addr;
		do @(posedge clk); while (!acc_if.ready);
		pending_results = {pending_results, predict_access(addr)};
	endtask

	task automatic wait_idle();
		acc_if.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic config_write(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value, input bit last);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			CFG_OFFSET_BITS: cfg_now.offset_bits = value[4:0];
			CFG_SET_BITS:    cfg_now.set_bits    = value[3:0];
			CFG_ACTIVE_WAYS: cfg_now.active_ways = value[2:0];
			CFG_POLICY:      cfg_now.policy      = value[0];
			default: ;
		endcase
		if (last)
			cfg_if.valid <= 1'b0;
	endtask

	task automatic apply_config(input int off, input int sb, input int ways, input logic pol);
		wait_idle();
		config_write(CFG_OFFSET_BITS, with_junk(32'(off), 5), 1'b0);
		config_write(CFG_SET_BITS, with_junk(32'(sb), 4), 1'b0);
		config_write(CFG_ACTIVE_WAYS, with_junk(32'(ways), 3), 1'b0);
		config_write(CFG_POLICY, with_junk(32'(pol), 1), 1'b1);
	endtask

	// reset settings: fully associative, 64-byte lines, four ways, LRU
	task automatic test_lru_basics();
		logic [31:0] seq [8];
		seq = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_003F, 32'h0000_0040,
			32'h0000_0080, 32'h0000_0000, 32'h0000_00C0, 32'hFFFF_FFC0};
		foreach (seq[i])
			send_access(seq[i]);
	endtask

	// a hit must not save a line from eviction under FIFO
	task automatic test_fifo_order();
		logic [31:0] seq [6];
		seq = '{32'h00, 32'h20, 32'h00, 32'h40, 32'h00, 32'h10};
		apply_config(4, 1, 2, POLICY_FIFO);
		foreach (seq[i])
			send_access(seq[i]);
	endtask

	// ways outside the active count keep their lines across setting changes
	task automatic test_inactive_ways();
		apply_config(6, 0, 1, POLICY_LRU);
		send_access(32'h0000_0000);
		send_access(32'h0000_1000);
		apply_config(6, 0, 0, POLICY_FIFO);
		send_access(32'h0000_2000);
		apply_config(6, 0, 7, POLICY_LRU);
		send_access(32'hFFFF_FFFF);
	endtask

	// shifts past the address width, set index folded onto the set count
	task automatic test_wide_fields();
		wait_idle();
		config_write(CFG_UNUSED_IDX, $urandom, 1'b1);
		apply_config(31, 15, 4, POLICY_LRU);
		send_access(32'h8000_0000);
		send_access(32'h7FFF_FFFF);
		apply_config(16, 15, 4, POLICY_LRU);
		send_access(32'hFFFF_0000);
		send_access(32'h7FFF_1234);
		apply_config(20, 12, 3, POLICY_FIFO);
		send_access(32'hABCD_E123);
		apply_config(0, 8, 4, POLICY_LRU);
		send_access(32'h1234_56FF);
		apply_config(0, 0, 4, POLICY_LRU);
		send_access(32'hFFFF_FFFF);
	endtask

	task automatic test_result_backpressure();
		apply_config(6, 2, 4, POLICY_LRU);
		hold_request = 1'b1;
		while (hold_request)
			@(posedge clk);
		no_gaps = 1'b1;
		for (int i = 0; i < 24; i++)
			send_access(32'(($urandom_range(0, 15) << 6) | $urandom_range(0, 63)));
		no_gaps = 1'b0;
	endtask

	// per phase: a few lines packed into two sets so hits and evictions both occur
	task automatic test_random_traffic();
		logic [31:0] pool [12];
		logic [63:0] set_mask;
		logic [63:0] offset_mask;
		logic [63:0] set_pick;
		int          pool_n;
		int          off;
		int          sb;
		int          ways;
		logic        pol;
		logic [31:0] set_a;
		logic [31:0] set_b;
		logic [31:0] addr;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin off = 0; sb = 0; ways = 1; pol = POLICY_LRU; end
				1: begin off = 31; sb = 15; ways = 7; pol = POLICY_FIFO; end
				2: begin off = 16; sb = 8; ways = 4; pol = POLICY_LRU; end
				default: begin
					off  = $urandom_range(0, 3) == 0 ? $urandom_range(0, 31) : $urandom_range(0, 16);
					sb   = $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom_range(0, 8);
					ways = $urandom_range(0, 7);
					pol  = 1'($urandom_range(0, 1));
				end
			endcase
			apply_config(off, sb, ways, pol);
			set_mask    = (64'd1 << sb) - 64'd1;
			offset_mask = (64'd1 << off) - 64'd1;
			set_a       = $urandom;
			set_b       = $urandom;
			pool_n      = $urandom_range(2, 12);
			for (int i = 0; i < pool_n; i++) begin
				set_pick = 64'((i % 2) ? set_b : set_a) & set_mask;
				pool[i]  = 32'((64'($urandom) << (off + sb)) | (set_pick << off));
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n % 10 == 0)
					no_gaps = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 3) == 0)
					addr = $urandom;
				else
					addr = pool[$urandom_range(0, pool_n - 1)] | (32'($urandom) & 32'(offset_mask));
				send_access(addr);
			end
			no_gaps = 1'b0;
		end
	endtask

	initial begin
		arst_n         <= 1'b0;
		acc_if.valid   <= 1'b0;
		acc_if.address <= '0;
		cfg_if.valid   <= 1'b0;
		cfg_if.index   <= '0;
		cfg_if.data    <= '0;
		cfg_now.offset_bits = OFFSET_BITS_RST;
		cfg_now.set_bits    = SET_BITS_RST;
		cfg_now.active_ways = ACTIVE_WAYS_RST;
		cfg_now.policy      = POLICY_LRU;
		for (int s = 0; s < SETS; s++) begin
			for (int w = 0; w < WAYS; w++) begin
				line_valid[s][w] = 1'b0;
				line_stamp[s][w] = '0;
			end
		end
		stamp_now   = '0;
		hits_seen   = '0;
		misses_seen = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_lru_basics();
		test_fifo_order();
		test_inactive_ways();
		test_wide_fields();
		test_result_backpressure();
		test_random_traffic();

		wait_idle();
		mismatches += pending_results.size();
		if (mismatches == 0)
			$display("[set_assoc_cache_lru_fifo_core] OK");
		else
			$display("[set_assoc_cache_lru_fifo_core] ERROR");
		$finish;
	end

	initial begin : drive_ready
		int run;
		res_if.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if ($urandom_range(0, 4) == 0) begin
				res_if.ready <= 1'b1;
				repeat ($urandom_range(40, 120)) @(posedge clk);
			end else begin
				res_if.ready <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				run = idle_len();
				if (run > 0) begin
					res_if.ready <= 1'b0;
					repeat (run) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin : check_results
		lookup_t want;
		if (res_if.valid && res_if.ready) begin
			if (pending_results.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: result with no access pending", $time);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (res_if.hit !== want.hit || res_if.hit_total !== want.hit_total ||
					res_if.miss_total !== want.miss_total) begin
					if (mismatches < 10)
						$display("%0t: result mismatch, expected hit %0b hits %0d misses %0d, got hit %0b hits %0d misses %0d",
							$time, want.hit, want.hit_total, want.miss_total,
							res_if.hit, res_if.hit_total, res_if.miss_total);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((acc_if.valid && acc_if.ready) || (res_if.valid && res_if.ready) ||
			(cfg_if.valid && cfg_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[set_assoc_cache_lru_fifo_core] ERROR");
			$finish;
		end
	end

endmodule
`default_nettype wire

[filelist.f]
sv/saclf_pkg.sv
sv/saclf_if.sv
sv/saclf_front.sv
sv/saclf_queue.sv
sv/saclf_back.sv
sv/set_assoc_cache_lru_fifo_core.sv
tb/set_assoc_cache_lru_fifo_core_tb.sv
